[hdl/pcg_pkg.sv]
// Shared types, constants and the output permutation of the PCG32 generator.
// Used by pcg_mul64, pcg_divu32 and pcg32_generator; depends on nothing.
package pcg_pkg;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = STATE_W / 2;

  // LCG multiplier, and the state that seeding from all-zero registers leaves.
  localparam logic [STATE_W-1:0] PCG_MULT        = 64'h5851_F42D_4C95_7F2D;
  localparam logic [STATE_W-1:0] PCG_RESET_STATE = 64'h5851_F42D_4C95_7F2E;
  localparam logic [STATE_W-1:0] PCG_RESET_INC   = 64'h0000_0000_0000_0001;

  // Configuration register indexes.
  localparam logic CFG_SEED_STATE    = 1'b0;
  localparam logic CFG_STREAM_SELECT = 1'b1;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_BOUNDED = 2'd1,
    OP_RESEED  = 2'd2,
    OP_NONE    = 2'd3
  } pcg_op_e;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } pcg_unit_sts_t;

  // XSH-RR output of a state word: xorshift, then rotate right by the top five bits.
  function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] mixed;
    logic [WORD_W-1:0]  xs;
    logic [4:0]         rot;
    logic [2*WORD_W-1:0] doubled;
    mixed   = ((s >> 18) ^ s) >> 27;
    xs      = mixed[WORD_W-1:0];
    rot     = s[STATE_W-1 -: 5];
    doubled = {xs, xs} >> rot;
    return doubled[WORD_W-1:0];
  endfunction

endpackage

[hdl/pcg_mul64.sv]
// Iterative LCG step: low 64 bits of a * PCG_MULT + increment.
// One shared 32x32 multiplier and one 64-bit adder; depends on pcg_pkg.
module pcg_mul64 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pcg_pkg::STATE_W-1:0]     a_i,
  input  logic [pcg_pkg::STATE_W-1:0]     inc_i,
  output logic [pcg_pkg::STATE_W-1:0]     result_o,
  output pcg_pkg::pcg_unit_sts_t          sts_o
);
  import pcg_pkg::*;

  typedef enum logic [2:0] {
    MS_LL,   // low x low product
    MS_LH,   // take low x low, form low x high
    MS_HL,   // add first cross term, form high x low
    MS_ADD,  // add second cross term
    MS_INC   // add the increment
  } mul_step_e;

  mul_step_e              step_q;
  logic                   busy_q;
  logic                   done_q;
  logic [STATE_W-1:0]     a_q;
  logic [STATE_W-1:0]     inc_q;
  logic [STATE_W-1:0]     prod_q;
  logic [STATE_W-1:0]     acc_q;
  logic [HALF_W-1:0]      op_a;
  logic [HALF_W-1:0]      op_b;
  logic [STATE_W-1:0]     prod_d;
  logic [STATE_W-1:0]     addend;

  always_comb begin
    op_a = a_q[HALF_W-1:0];
    op_b = PCG_MULT[HALF_W-1:0];
    case (step_q)
      MS_LH:   op_b = PCG_MULT[STATE_W-1:HALF_W];
      MS_HL:   op_a = a_q[STATE_W-1:HALF_W];
      default: ;
    endcase
    prod_d = STATE_W'(op_a) * STATE_W'(op_b);
    addend = (step_q == MS_INC) ? inc_q : {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MS_LL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= MS_LL;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        unique case (step_q)
          MS_LL:   step_q <= MS_LH;
          MS_LH:   step_q <= MS_HL;
          MS_HL:   step_q <= MS_ADD;
          MS_ADD:  step_q <= MS_INC;
          MS_INC: begin
            step_q <= MS_LL;
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
          default: step_q <= MS_LL;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      inc_q <= inc_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
      if (step_q == MS_LH) begin
        acc_q <= prod_q;
      end else if (step_q != MS_LL) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign result_o = acc_q;
  assign sts_o    = '{busy: busy_q, done: done_q};

endmodule

[hdl/pcg_divu32.sv]
// Restoring 32-bit remainder unit, one quotient bit per cycle.
// Gives numerator mod divisor after 32 steps; depends on pcg_pkg.
module pcg_divu32 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pcg_pkg::WORD_W-1:0]  num_i,
  input  logic [pcg_pkg::WORD_W-1:0]  div_i,
  output logic [pcg_pkg::WORD_W-1:0]  rem_o,
  output pcg_pkg::pcg_unit_sts_t      sts_o
);
  import pcg_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [WORD_W-1:0] num_q;
  logic [WORD_W-1:0] div_q;
  logic [WORD_W-1:0] rem_q;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, num_q[WORD_W-1]};
    diff  = trial - {1'b0, div_q};
    rem_d = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      div_q <= div_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[WORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;
  assign sts_o = '{busy: busy_q, done: done_q};

endmodule

[hdl/pcg32_generator.sv]
// PCG32 XSH-RR generator top level: sequencer, state, config and output word register.
// A raw draw or reseed raises its output word after one iterative 64-bit multiply-add; a
// bounded request adds two remainder passes, for the threshold and for the reduction, and
// one more multiply-add for every rejected draw. One request is in flight; the next is
// accepted the cycle after its word is raised. Reset seeds from zeroed registers: state
// 0x5851F42D4C957F2E, increment 1.
module pcg32_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [pcg_pkg::WORD_W-1:0]     bound_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pcg_pkg::WORD_W-1:0]     value_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [pcg_pkg::STATE_W-1:0]    cfg_data_i
);
  import pcg_pkg::*;

  // The sequencer walks one request through the shared multiply-add and remainder
  // units. A bounded request first works out the rejection threshold, then draws
  // until the raw word clears it, and finally reduces the accepted word modulo bound.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THRESH,
    ST_DRAW,
    ST_MULW,
    ST_REMW,
    ST_FINISH
  } gen_state_e;

  gen_state_e             state_q;
  logic [STATE_W-1:0]     lcg_q;
  logic [STATE_W-1:0]     inc_q;
  logic [STATE_W-1:0]     seed_state_q;
  logic [STATE_W-2:0]     stream_q;
  logic [WORD_W-1:0]      bound_q;
  logic [WORD_W-1:0]      thresh_q;
  logic [WORD_W-1:0]      word_q;
  logic [WORD_W-1:0]      div_num_q;
  logic                   bounded_q;
  logic                   mul_go_q;
  logic                   div_go_q;
  logic                   out_valid_q;
  logic [WORD_W-1:0]      value_q;

  logic                   in_accept;
  logic [STATE_W-1:0]     new_inc;
  logic [STATE_W-1:0]     mul_result;
  logic [WORD_W-1:0]      div_rem;
  pcg_unit_sts_t          mul_sts;
  pcg_unit_sts_t          div_sts;
  pcg_op_e                req_op;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign req_op      = pcg_op_e'(operation_i);
  assign new_inc     = {stream_q, 1'b1};
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  pcg_mul64 u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go_q),
    .a_i      (lcg_q),
    .inc_i    (inc_q),
    .result_o (mul_result),
    .sts_o    (mul_sts)
  );

  pcg_divu32 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .div_i   (bound_q),
    .rem_o   (div_rem),
    .sts_o   (div_sts)
  );

  // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_state_q <= '0;
      stream_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SEED_STATE:    seed_state_q <= cfg_data_i;
        CFG_STREAM_SELECT: stream_q     <= cfg_data_i[STATE_W-2:0];
        default: ;
      endcase
    end
  end

  // Sequencer, generator state and the output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lcg_q       <= PCG_RESET_STATE;
      inc_q       <= PCG_RESET_INC;
      bound_q     <= '0;
      thresh_q    <= '0;
      word_q      <= '0;
      div_num_q   <= '0;
      bounded_q   <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            bounded_q <= 1'b0;
            unique case (req_op)
              OP_RAW: begin
                word_q   <= xsh_rr(lcg_q);
                mul_go_q <= 1'b1;
                state_q  <= ST_MULW;
              end
              OP_BOUNDED: begin
                if (bound_i == '0) begin
                  // A zero bound behaves as a raw draw.
                  word_q   <= xsh_rr(lcg_q);
                  mul_go_q <= 1'b1;
                  state_q  <= ST_MULW;
                end else begin
                  bounded_q <= 1'b1;
                  bound_q   <= bound_i;
                  div_num_q <= WORD_W'(0) - bound_i;
                  div_go_q  <= 1'b1;
                  state_q   <= ST_THRESH;
                end
              end
              OP_RESEED: begin
                // The first seeding draw from zero state leaves the increment, so
                // it folds into one add; the second draw runs on the multiplier.
                inc_q    <= new_inc;
                lcg_q    <= new_inc + seed_state_q;
                word_q   <= '0;
                mul_go_q <= 1'b1;
                state_q  <= ST_MULW;
              end
              OP_NONE: begin
                word_q  <= '0;
                state_q <= ST_FINISH;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_THRESH: begin
          if (div_sts.done) begin
            thresh_q <= div_rem;
            state_q  <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          word_q   <= xsh_rr(lcg_q);
          mul_go_q <= 1'b1;
          state_q  <= ST_MULW;
        end
        ST_MULW: begin
          if (mul_sts.done) begin
            lcg_q <= mul_result;
            if (!bounded_q) begin
              state_q <= ST_FINISH;
            end else if (word_q >= thresh_q) begin
              div_num_q <= word_q;
              div_go_q  <= 1'b1;
              state_q   <= ST_REMW;
            end else begin
              state_q <= ST_DRAW;
            end
          end
        end
        ST_REMW: begin
          if (div_sts.done) begin
            word_q  <= div_rem;
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // The output register takes the word once its previous word has gone.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            value_q     <= word_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_inc_odd : assert property (@(posedge clk_i) disable iff (!rst_ni) inc_q[0])
    else $error("increment is even");

  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and remainder unit busy together");

  a_mul_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.done |-> (state_q == ST_MULW))
    else $error("multiply-add finished outside its wait state");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> ((state_q == ST_THRESH) || (state_q == ST_REMW)))
    else $error("remainder finished outside its wait states");

  a_rem_below_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (div_rem < bound_q))
    else $error("remainder not below bound");

endmodule

[test/tb_pcg32_generator.sv]
// Self-checking testbench for pcg32_generator: request words are driven with random idling,
// every output word is predicted by a scoreboard and compared in order of arrival.
// Depends on pcg_pkg for the port widths, the operation codes and the register indexes.
module tb_pcg32_generator;
  import pcg_pkg::*;

  // LCG multiplier of the PCG32 family, kept here so that the prediction stands on its own.
  localparam logic [STATE_W-1:0] LCG_MULTIPLIER = 64'd6364136223846793005;

  // Scoreboard: a private copy of the generator state and of both registers. Each accepted
  // request word is turned into the output word it must produce, and the output words are
  // then checked strictly in order, since only one request is ever in flight.
  class pcg32_scoreboard;
    logic [STATE_W-1:0] lcg;
    logic [STATE_W-1:0] incr;
    logic [STATE_W-1:0] seed_reg;
    logic [62:0]        stream_reg;
    logic [WORD_W-1:0]  expected_words[$];
    int unsigned        mismatches;

    function new();
      seed_reg   = '0;
      stream_reg = '0;
      mismatches = 0;
      reseed();
    endfunction

    // One LCG step. The word returned is the xorshift of the old state, rotated right by
    // its top five bits.
    function logic [WORD_W-1:0] advance();
      logic [STATE_W-1:0] old;
      logic [STATE_W-1:0] mixed;
      logic [WORD_W-1:0]  xs;
      int unsigned        rot;
      old   = lcg;
      lcg   = old * LCG_MULTIPLIER + incr;
      mixed = ((old >> 18) ^ old) >> 27;
      xs    = mixed[WORD_W-1:0];
      rot   = old[STATE_W-1 -: 5];
      if (rot == 0) begin
        return xs;
      end
      return (xs >> rot) | (xs << (WORD_W - rot));
    endfunction

    function void reseed();
      logic [WORD_W-1:0] discard;
      lcg     = '0;
      incr    = {stream_reg, 1'b1};
      discard = advance();
      lcg     = lcg + seed_reg;
      discard = advance();
    endfunction

    // Rejection sampling: draw until the word clears (2^32 - limit) mod limit.
    function logic [WORD_W-1:0] bounded_word(logic [WORD_W-1:0] limit);
      logic [WORD_W-1:0] negated;
      logic [WORD_W-1:0] threshold;
      logic [WORD_W-1:0] r;
      if (limit == '0) begin
        return advance();
      end
      negated   = '0 - limit;
      threshold = negated % limit;
      do begin
        r = advance();
      end while (r < threshold);
      return r % limit;
    endfunction

    function void note_config(logic idx, logic [STATE_W-1:0] data);
      if (idx == CFG_SEED_STATE) begin
        seed_reg = data;
      end else begin
        stream_reg = data[62:0];
      end
    endfunction

    function void note_request(pcg_op_e op, logic [WORD_W-1:0] limit);
      logic [WORD_W-1:0] word;
      word = '0;
      case (op)
        OP_RAW:     word = advance();
        OP_BOUNDED: word = bounded_word(limit);
        OP_RESEED:  reseed();
        default:    word = '0;
      endcase
      expected_words.push_back(word);
    endfunction

    function void check_word(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: output word %h arrived with nothing pending", $realtime, got);
        end
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: value mismatch, expected %h, got %h", $realtime, want, got);
        end
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           operation_i = 2'd0;
  logic [WORD_W-1:0]    bound_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [WORD_W-1:0]    value_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i = 1'b0;
  logic [STATE_W-1:0]   cfg_data_i  = '0;

  // While set, neither the request side nor the result side idles.
  logic                 calm        = 1'b0;

  pcg32_scoreboard board;

  pcg32_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .bound_i     (bound_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random, with a chance of about 37 in a hundred, except in the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 37);
  end

  // Output words are taken at the edge where valid is high and stall is low. Both are
  // sampled before this edge's updates land, so the check does not race the block.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_word(value_o);
    end
  end

  // Random gap before a request word. Valid is only lowered when a gap really follows,
  // so a valid that stays high is never dropped and raised within one time step.
  task automatic pause_sender();
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 37) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_request(pcg_op_e op, logic [WORD_W-1:0] limit);
    pause_sender();
    in_valid_i  <= 1'b1;
    operation_i <= op;
    bound_i     <= limit;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    board.note_request(op, limit);
  endtask

  task automatic send_random_request();
    pcg_op_e           op;
    logic [WORD_W-1:0] limit;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      op = OP_RAW;
    end else if (pick < 82) begin
      op = OP_BOUNDED;
    end else if (pick < 92) begin
      op = OP_RESEED;
    end else begin
      op = OP_NONE;
    end
    case ($urandom_range(0, 7))
      0: limit = '0;
      1: limit = 32'd1;
      2: limit = $urandom_range(2, 17);
      3: limit = 32'd1 << $urandom_range(1, 31);
      // Just above half the range the threshold is near 2^31, so draws are often rejected.
      4: limit = 32'h8000_0000 | $urandom_range(1, 255);
      default: limit = $urandom();
    endcase
    send_request(op, limit);
  endtask

  task automatic write_register(logic idx, logic [STATE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    board.note_config(idx, data);
  endtask

  // Every request word yields exactly one output word, so an empty queue means idle; the
  // short wait after it simply lets the sequencer settle before any register is touched.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (board.expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    logic [STATE_W-1:0] seed_value;
    logic [STATE_W-1:0] stream_value;
    int unsigned        phase;
    int unsigned        n;

    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the state that reset leaves behind. It covers raw
    // draws, bounds of zero and one, powers of two, bounds just above half the range with
    // heavy rejection, the largest bound, a reseed and the unused operation code.
    send_request(OP_RAW, '0);
    send_request(OP_RAW, '1);
    send_request(OP_BOUNDED, 32'd0);
    send_request(OP_BOUNDED, 32'd1);
    send_request(OP_BOUNDED, 32'd2);
    send_request(OP_BOUNDED, 32'd3);
    send_request(OP_BOUNDED, 32'hFFFF_FFFF);
    send_request(OP_BOUNDED, 32'h8000_0000);
    send_request(OP_BOUNDED, 32'h8000_0001);
    send_request(OP_BOUNDED, 32'h8000_0003);
    send_request(OP_BOUNDED, 32'h7FFF_FFFF);
    send_request(OP_BOUNDED, 32'h5555_5556);
    send_request(OP_NONE, '1);
    send_request(OP_NONE, '0);
    send_request(OP_RAW, 32'hA5A5_A5A5);
    send_request(OP_RESEED, '1);
    send_request(OP_RAW, '0);
    send_request(OP_BOUNDED, 32'd6);
    send_request(OP_RESEED, '0);
    send_request(OP_BOUNDED, 32'd1000);
    send_request(OP_RAW, 32'h5A5A_5A5A);
    wait_until_idle();

    // Random part in five phases, each under its own register setting: all ones (the top
    // bit of the stream word must be dropped), all zeros, random, a lone top bit on the
    // stream that leaves stream zero, and random again. The last phase does not reseed at
    // once, so the old stream must carry on until a random reseed comes along.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          seed_value   = '1;
          stream_value = '1;
        end
        1: begin
          seed_value   = '0;
          stream_value = '0;
        end
        3: begin
          seed_value   = 64'd1;
          stream_value = 64'h8000_0000_0000_0000;
        end
        default: begin
          seed_value   = {$urandom(), $urandom()};
          stream_value = {$urandom(), $urandom()};
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_register(CFG_SEED_STATE, seed_value);
        write_register(CFG_STREAM_SELECT, stream_value);
      end else begin
        write_register(CFG_STREAM_SELECT, stream_value);
        write_register(CFG_SEED_STATE, seed_value);
      end
      if (phase != 4) begin
        send_request(OP_RESEED, $urandom());
      end
      for (n = 0; n < 180; n++) begin
        // A long stretch in the middle phase runs back to back on both sides.
        calm = (phase == 2) && (n < 120);
        send_random_request();
      end
      calm = 1'b0;
      wait_until_idle();
    end

    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("tb_pcg32_generator: PASS");
    end else begin
      $display("tb_pcg32_generator: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with long rejection chains.
  initial begin
    #20_000_000;
    $display("tb_pcg32_generator: FAIL");
    $finish;
  end

endmodule

[files.f]
hdl/pcg_pkg.sv
hdl/pcg_mul64.sv
hdl/pcg_divu32.sv
hdl/pcg32_generator.sv
test/tb_pcg32_generator.sv
